### rtl/core/tcab_pkg.sv
// Shared types and codes for the ALU and branch execute block.
// No dependencies; tcab_regfile, tcab_exec and the top level refer to it by scoped names.
package tcab_pkg;

  // Register numbers with a fixed role
  localparam logic [3:0] REG_LINK   = 4'd13;
  localparam logic [3:0] REG_STATUS = 4'd14;
  localparam logic [3:0] REG_ADDR   = 4'd15;

  // Instruction actions
  typedef enum logic [3:0] {
    ACT_ADD  = 4'd0,
    ACT_ADDI = 4'd1,
    ACT_SUB  = 4'd2,
    ACT_AND  = 4'd3,
    ACT_OR   = 4'd4,
    ACT_XOR  = 4'd5,
    ACT_LSH  = 4'd6,
    ACT_RSH  = 4'd7,
    ACT_CMP  = 4'd8,
    ACT_BIMM = 4'd9,
    ACT_BREG = 4'd10,
    ACT_CIMM = 4'd11,
    ACT_CREG = 4'd12,
    ACT_BRT  = 4'd13
  } action_t;

  // Compare modes, all signed
  typedef enum logic [3:0] {
    CMP_EQ = 4'd0,
    CMP_GE = 4'd1,
    CMP_GT = 4'd2,
    CMP_NE = 4'd8,
    CMP_LT = 4'd9,
    CMP_LE = 4'd10
  } cmp_mode_t;

  // One decoded instruction as held in the execute stage
  typedef struct packed {
    logic [3:0]  action;
    logic [3:0]  dest_reg;
    logic [3:0]  src_a_reg;
    logic [3:0]  src_b_reg;
    logic [7:0]  imm_value;
    logic [3:0]  compare_mode;
    logic        is_conditional;
    logic [31:0] instr_addr;
  } instr_t;

  // Register file write from execute to storage
  typedef struct packed {
    logic        en;
    logic [3:0]  addr;
    logic [31:0] data;
  } wr_t;

  // One result item
  typedef struct packed {
    logic [31:0] next_pc;
    logic [31:0] alu_value;
    logic [7:0]  status_low;
  } result_t;

endpackage

### rtl/core/tcab_if.sv
// Valid/ready channel interfaces for instruction requests and results.
// Depends on nothing; used by the top level.
interface tcab_in_if;
  logic              valid;
  logic              ready;
  logic [3:0]        action;
  logic [3:0]        dest_reg;
  logic [3:0]        src_a_reg;
  logic [3:0]        src_b_reg;
  logic signed [7:0] imm_value;
  logic [3:0]        compare_mode;
  logic              is_conditional;
  logic [31:0]       instr_addr;

  modport source (
    output valid, action, dest_reg, src_a_reg, src_b_reg, imm_value,
           compare_mode, is_conditional, instr_addr,
    input  ready
  );
  modport sink (
    input  valid, action, dest_reg, src_a_reg, src_b_reg, imm_value,
           compare_mode, is_conditional, instr_addr,
    output ready
  );
endinterface

interface tcab_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        next_pc;
  logic signed [31:0] alu_value;
  logic [7:0]         status_low;

  modport source (
    output valid, next_pc, alu_value, status_low,
    input  ready
  );
  modport sink (
    input  valid, next_pc, alu_value, status_low,
    output ready
  );
endinterface

### rtl/core/tcab_regfile.sv
// General register storage: two synchronous memories with registered reads,
// valid bits for reset-to-zero and a bypass for the write that lands with a read.
// Depends on tcab_pkg.
module tcab_regfile (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [3:0]       rd_addr_a,
  input  logic [3:0]       rd_addr_b,
  input  logic [3:0]       rd_addr_d,
  input  tcab_pkg::wr_t    wr,
  output logic [31:0]      data_a,
  output logic [31:0]      data_b,
  output logic [31:0]      data_d
);

  // Two copies give three read ports in total
  logic [31:0] mem_ab [16];
  logic [31:0] mem_d  [16];
  logic [15:0] valid;

  logic [31:0] q_a, q_b, q_d;
  logic        qv_a, qv_b, qv_d;
  logic [3:0]  addr_a, addr_b, addr_d;

  logic        byp_valid;
  logic [3:0]  byp_addr;
  logic [31:0] byp_data;

  // Write both copies
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_ab[wr.addr] <= wr.data;
      mem_d[wr.addr]  <= wr.data;
    end
  end

  // Read on request, data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_a    <= mem_ab[rd_addr_a];
      q_b    <= mem_ab[rd_addr_b];
      q_d    <= mem_d[rd_addr_d];
      addr_a <= rd_addr_a;
      addr_b <= rd_addr_b;
      addr_d <= rd_addr_d;
    end
  end

  // Valid bits: cleared by reset, set on first write, sampled with the read
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      qv_a  <= 1'b0;
      qv_b  <= 1'b0;
      qv_d  <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        qv_a <= valid[rd_addr_a];
        qv_b <= valid[rd_addr_b];
        qv_d <= valid[rd_addr_d];
      end
    end
  end

  // Hold the latest write; it covers a write that lands in the read's cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else if (wr.en) begin
      byp_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      byp_addr <= wr.addr;
      byp_data <= wr.data;
    end
  end

  // Forward the bypass, else memory data, else the reset value
  always_comb begin
    data_a = qv_a ? q_a : '0;
    data_b = qv_b ? q_b : '0;
    data_d = qv_d ? q_d : '0;
    if (byp_valid && byp_addr == addr_a) begin
      data_a = byp_data;
    end
    if (byp_valid && byp_addr == addr_b) begin
      data_b = byp_data;
    end
    if (byp_valid && byp_addr == addr_d) begin
      data_d = byp_data;
    end
  end

endmodule

### rtl/core/tcab_exec.sv
// Execute unit: ALU, compare, branch target, status, address and PC registers.
// Depends on tcab_pkg; writes general registers through tcab_regfile.
module tcab_exec (
  input  logic                clk,
  input  logic                rst,
  input  logic                commit,
  input  tcab_pkg::instr_t    ins,
  input  logic [31:0]         mem_a,
  input  logic [31:0]         mem_b,
  input  logic [31:0]         mem_d,
  output tcab_pkg::wr_t       wr,
  output tcab_pkg::result_t   res
);

  logic [7:0]  status, status_next;
  logic [31:0] last_seq;
  logic [31:0] pc, pc_next;

  logic [31:0] va, vb, vd, imm_ext, seq, alu, br_target;
  logic [4:0]  sh;
  logic        taken, is_alu, link_wr;

  // Registers 14 and 15 live in flops, not in the memory
  function automatic logic [31:0] pick(
    input logic [3:0]  idx,
    input logic [31:0] mem_val,
    input logic [7:0]  st,
    input logic [31:0] ls
  );
    logic [31:0] v;
    v = mem_val;
    if (idx == tcab_pkg::REG_STATUS) begin
      v = {24'd0, st};
    end else if (idx == tcab_pkg::REG_ADDR) begin
      v = ls;
    end
    return v;
  endfunction

  // Operands and common terms
  always_comb begin
    va        = pick(ins.src_a_reg, mem_a, status, last_seq);
    vb        = pick(ins.src_b_reg, mem_b, status, last_seq);
    vd        = pick(ins.dest_reg, mem_d, status, last_seq);
    imm_ext   = {{24{ins.imm_value[7]}}, ins.imm_value};
    seq       = ins.instr_addr + 32'd2;
    sh        = {1'b0, ins.imm_value[3:0]} + 5'd1;
    br_target = ins.instr_addr + {imm_ext[30:0], 1'b0};
    taken     = !ins.is_conditional || status[1];
  end

  // Decode and compute
  always_comb begin
    alu         = '0;
    is_alu      = 1'b0;
    link_wr     = 1'b0;
    status_next = status;
    pc_next     = seq;
    unique case (ins.action)
      tcab_pkg::ACT_ADD: begin
        alu            = va + vb;
        is_alu         = 1'b1;
        status_next[0] = (alu[31] ^ va[31]) & (alu[31] ^ vb[31]);
      end
      tcab_pkg::ACT_ADDI: begin
        alu            = vd + imm_ext;
        is_alu         = 1'b1;
        status_next[0] = (alu[31] ^ vd[31]) & (alu[31] ^ imm_ext[31]);
      end
      tcab_pkg::ACT_SUB: begin
        alu            = va - vb;
        is_alu         = 1'b1;
        status_next[0] = (va[31] ^ alu[31]) & (va[31] ^ vb[31]);
      end
      tcab_pkg::ACT_AND: begin
        alu    = va & vb;
        is_alu = 1'b1;
      end
      tcab_pkg::ACT_OR: begin
        alu    = va | vb;
        is_alu = 1'b1;
      end
      tcab_pkg::ACT_XOR: begin
        alu    = va ^ vb;
        is_alu = 1'b1;
      end
      tcab_pkg::ACT_LSH: begin
        alu    = va << sh;
        is_alu = 1'b1;
      end
      tcab_pkg::ACT_RSH: begin
        alu    = va >> sh;
        is_alu = 1'b1;
      end
      tcab_pkg::ACT_CMP: begin
        unique case (ins.compare_mode)
          tcab_pkg::CMP_EQ: status_next[1] = (va == vb);
          tcab_pkg::CMP_NE: status_next[1] = (va != vb);
          tcab_pkg::CMP_GT: status_next[1] = ($signed(vb) < $signed(va));
          tcab_pkg::CMP_GE: status_next[1] = !($signed(va) < $signed(vb));
          tcab_pkg::CMP_LT: status_next[1] = ($signed(va) < $signed(vb));
          tcab_pkg::CMP_LE: status_next[1] = !($signed(vb) < $signed(va));
          default:          status_next[1] = status[1];
        endcase
      end
      tcab_pkg::ACT_BIMM: begin
        if (taken) begin
          pc_next = br_target;
        end
      end
      tcab_pkg::ACT_BREG: begin
        if (taken) begin
          pc_next = {va[31:1], 1'b0};
        end
      end
      tcab_pkg::ACT_CIMM: begin
        if (taken) begin
          link_wr = 1'b1;
          pc_next = br_target;
        end
      end
      tcab_pkg::ACT_CREG: begin
        if (taken) begin
          link_wr = 1'b1;
          // the link write comes first, so reading register 13 gives it back
          pc_next = (ins.src_a_reg == tcab_pkg::REG_LINK) ? seq : va;
        end
      end
      tcab_pkg::ACT_BRT: begin
        if (taken) begin
          pc_next = pc + {va[30:0], 1'b0};
        end
      end
      default: begin
        pc_next = seq;
      end
    endcase

    // Status register takes only bits 7..4 of an ALU write
    if (is_alu && ins.dest_reg == tcab_pkg::REG_STATUS) begin
      status_next[7:4] = alu[7:4];
    end
  end

  // General register write: ALU result below 14, or the link on a call
  always_comb begin
    wr.en   = 1'b0;
    wr.addr = ins.dest_reg;
    wr.data = alu;
    if (is_alu && ins.dest_reg < tcab_pkg::REG_LINK + 4'd1) begin
      wr.en = commit;
    end else if (link_wr) begin
      wr.en   = commit;
      wr.addr = tcab_pkg::REG_LINK;
      wr.data = seq;
    end
  end

  // Result item
  always_comb begin
    res.next_pc    = pc_next;
    res.alu_value  = alu;
    res.status_low = status_next;
  end

  // Advance status, address register and PC as each item retires
  always_ff @(posedge clk) begin
    if (rst) begin
      status   <= '0;
      last_seq <= '0;
      pc       <= '0;
    end else if (commit) begin
      status   <= status_next;
      last_seq <= seq;
      pc       <= pc_next;
    end
  end

endmodule

### rtl/core/tiny_cpu_alu_branch_execute.sv
// Execute stage of a small 32-bit core: ALU, compare and branch against a
// 16-word register file. Depends on tcab_pkg, tcab_if, tcab_regfile, tcab_exec.
//
// Usage:
//   instr  - request channel, one decoded instruction per request, accepted
//            when valid and ready are both high at a rising edge of clk.
//   result - one result per request (next_pc, alu_value, status_low), in order.
// A request accepted passes the execute stage register, then the output register.
// Throughput: one request per cycle while results are taken. The general
// registers sit in synchronous memories read in the accept cycle; the execute
// stage then computes and writes back, and a bypass register feeds a write that
// lands in the same cycle as a later read. Registers 14 and 15 and the PC are flops.
// Reset (rst, synchronous): all registers and the PC read as zero on the next
// request; instr.ready is low while rst is high. No clearing pass is needed.
// Stall: the result register holds while result.ready is low; one more request
// is taken into the execute stage, after which instr.ready drops until the
// result is taken.
module tiny_cpu_alu_branch_execute (
  input logic        clk,
  input logic        rst,
  tcab_in_if.sink    instr,
  tcab_out_if.source result
);

  logic                ex_valid;
  tcab_pkg::instr_t    ex_ins;
  logic                accept, ex_advance;
  logic [31:0]         mem_a, mem_b, mem_d;
  tcab_pkg::wr_t       wr;
  tcab_pkg::result_t   ex_res;
  logic                out_valid;
  tcab_pkg::result_t   out_res;

  // Handshake control
  assign ex_advance  = ex_valid && (!out_valid || result.ready);
  assign instr.ready = !rst && (!ex_valid || ex_advance);
  assign accept      = instr.valid && instr.ready;

  // Execute stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else if (accept) begin
      ex_valid <= 1'b1;
    end else if (ex_advance) begin
      ex_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ex_ins.action         <= instr.action;
      ex_ins.dest_reg       <= instr.dest_reg;
      ex_ins.src_a_reg      <= instr.src_a_reg;
      ex_ins.src_b_reg      <= instr.src_b_reg;
      ex_ins.imm_value      <= instr.imm_value;
      ex_ins.compare_mode   <= instr.compare_mode;
      ex_ins.is_conditional <= instr.is_conditional;
      ex_ins.instr_addr     <= instr.instr_addr;
    end
  end

  // Register storage, read as a request is accepted
  tcab_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr_a (instr.src_a_reg),
    .rd_addr_b (instr.src_b_reg),
    .rd_addr_d (instr.dest_reg),
    .wr        (wr),
    .data_a    (mem_a),
    .data_b    (mem_b),
    .data_d    (mem_d)
  );

  // Compute and retire
  tcab_exec u_exec (
    .clk    (clk),
    .rst    (rst),
    .commit (ex_advance),
    .ins    (ex_ins),
    .mem_a  (mem_a),
    .mem_b  (mem_b),
    .mem_d  (mem_d),
    .wr     (wr),
    .res    (ex_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ex_advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_advance) begin
      out_res <= ex_res;
    end
  end

  assign result.valid      = out_valid;
  assign result.next_pc    = out_res.next_pc;
  assign result.alu_value  = $signed(out_res.alu_value);
  assign result.status_low = out_res.status_low;

endmodule

### rtl/core/tcab_checker.sv
// Port-level checks for the execute block, attached by bind.
// Depends on the top level's ports only.
module tcab_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_status
);

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A fresh result follows an accepted request through the execute stage and output registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching request");

  // Status bits 3 and 2 are never written
  a_status_bits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_status[3:2] == 2'b00))
    else $error("unused status bits set");

  // With the result stalled and one request taken in, stop taking requests
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && $past(out_valid && !out_ready)
     && $past(in_valid && in_ready)) |-> !in_ready)
    else $error("request accepted past a full execute stage");

endmodule

bind tiny_cpu_alu_branch_execute tcab_checker u_tcab_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (instr.valid),
  .in_ready   (instr.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_status (result.status_low)
);
